### design/serial_mouse_report_encoder_core_assert.svh
// Assertion macros shared by the serial mouse report encoder modules.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SERIAL_MOUSE_REPORT_ENCODER_CORE_ASSERT_SVH
`define SERIAL_MOUSE_REPORT_ENCODER_CORE_ASSERT_SVH

// Clocked property, off while in reset.
`define SMRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define SMRE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

### design/smre_pkg.sv
// Package for the serial mouse report encoder: codes, report type, clamp helper.
// No dependencies.
package smre_pkg;

  localparam int ReportLen  = 5;
  localparam int CntW       = $clog2(ReportLen);
  localparam int QueueDepth = 2;

  localparam logic ReqMove   = 1'b0;
  localparam logic ReqButton = 1'b1;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;

  localparam logic [1:0] BtnLeft   = 2'd0;
  localparam logic [1:0] BtnMiddle = 2'd1;
  localparam logic [1:0] BtnRight  = 2'd2;

  localparam logic [2:0] MaskLeft   = 3'h4;
  localparam logic [2:0] MaskMiddle = 3'h2;
  localparam logic [2:0] MaskRight  = 3'h1;
  localparam logic [2:0] ButtonsReleased = 3'h7;

  localparam logic [7:0] SyncByte = 8'h80;

  localparam logic signed [16:0] ClampLo = -17'sd120;
  localparam logic signed [16:0] ClampHi = 17'sd127;

  typedef logic [ReportLen-1:0][7:0] report_t;

  typedef enum logic [1:0] {
    EvNone,
    EvMoveX,
    EvMoveY,
    EvButton
  } event_e;

  function automatic logic [7:0] clamp_delta(input logic signed [16:0] d);
    logic signed [16:0] c;
    if (d < ClampLo) begin
      c = ClampLo;
    end else if (d > ClampHi) begin
      c = ClampHi;
    end else begin
      c = d;
    end
    return c[7:0];
  endfunction

endpackage

### design/smre_front.sv
// Front end: accepts pointer events, tracks button bits, builds five-byte reports.
// Depends on smre_pkg.
module smre_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [1:0]            move_axis_i,
  input  logic signed [15:0]    move_value_i,
  input  logic [1:0]            button_id_i,
  input  logic                  pressed_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output smre_pkg::report_t     q_data_o
);

  logic [2:0]          buttons_q, buttons_d;
  logic [2:0]          mask;
  logic                accept;
  smre_pkg::event_e    ev;
  logic signed [16:0]  dx, dy;
  logic [7:0]          x1, y1;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    ev   = smre_pkg::EvNone;
    mask = 3'h0;
    if (req_type_i == smre_pkg::ReqMove) begin
      unique case (move_axis_i)
        smre_pkg::AxisX: ev = smre_pkg::EvMoveX;
        smre_pkg::AxisY: ev = smre_pkg::EvMoveY;
        default:         ev = smre_pkg::EvNone;
      endcase
    end else begin
      unique case (button_id_i)
        smre_pkg::BtnLeft:   begin ev = smre_pkg::EvButton; mask = smre_pkg::MaskLeft;   end
        smre_pkg::BtnMiddle: begin ev = smre_pkg::EvButton; mask = smre_pkg::MaskMiddle; end
        smre_pkg::BtnRight:  begin ev = smre_pkg::EvButton; mask = smre_pkg::MaskRight;  end
        default:             ev = smre_pkg::EvNone;
      endcase
    end
  end

  always_comb begin
    buttons_d = buttons_q;
    if (accept && ev == smre_pkg::EvButton) begin
      buttons_d = pressed_i ? (buttons_q & ~mask) : (buttons_q | mask);
    end
  end

  // Y goes out positive upwards; 17 bits hold the negated most negative value
  always_comb begin
    dx = 17'sd0;
    dy = 17'sd0;
    if (ev == smre_pkg::EvMoveX) begin
      dx = 17'(move_value_i);
    end else if (ev == smre_pkg::EvMoveY) begin
      dy = -(17'(move_value_i));
    end
  end

  assign x1 = smre_pkg::clamp_delta(dx);
  assign y1 = smre_pkg::clamp_delta(dy);

  always_comb begin
    q_data_o[0] = smre_pkg::SyncByte | {5'd0, buttons_d};
    q_data_o[1] = x1;
    q_data_o[2] = y1;
    q_data_o[3] = dx[7:0] - x1;
    q_data_o[4] = dy[7:0] - y1;
  end

  assign q_push_o = accept && (ev != smre_pkg::EvNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buttons_q <= smre_pkg::ButtonsReleased;
    end else begin
      buttons_q <= buttons_d;
    end
  end

endmodule

### design/smre_fifo.sv
// Short report queue between front end and byte sequencer.
// Depends on smre_pkg and serial_mouse_report_encoder_core_assert.svh.
`include "serial_mouse_report_encoder_core_assert.svh"

module smre_fifo #(
  parameter int Depth = smre_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smre_pkg::report_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output smre_pkg::report_t data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  smre_pkg::report_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SMRE_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(Depth), "queue count above depth")
  `SMRE_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `SMRE_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")
  `SMRE_ASSERT(a_cnt_grow, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1, "count did not grow")

endmodule

### design/smre_back.sv
// Byte sequencer: sends the head report one byte per cycle, when not stalled, through an output register.
// Depends on smre_pkg and serial_mouse_report_encoder_core_assert.svh.
`include "serial_mouse_report_encoder_core_assert.svh"

module smre_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  smre_pkg::report_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        report_byte_o,
  output logic              last_of_report_o
);

  localparam logic [smre_pkg::CntW-1:0] LastIdx = smre_pkg::CntW'(smre_pkg::ReportLen - 1);

  logic [smre_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                byte_q;
  logic                      last_q;
  logic                      load, at_last;

  assign at_last = (cnt_q == LastIdx);
  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o   = load & at_last;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      cnt_d       = at_last ? '0 : cnt_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i[cnt_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_byte_o    = byte_q;
  assign last_of_report_o = last_q;

  `SMRE_ASSERT_ALWAYS(a_cnt_range, cnt_q <= LastIdx, "byte index past report end")
  `SMRE_ASSERT(a_pop_head, pop_o |-> head_valid_i, "pop without a report")
  `SMRE_ASSERT(a_pop_last, pop_o |=> out_valid_q && last_q && cnt_q == '0, "pop not on last byte")

endmodule

### design/serial_mouse_report_encoder_core.sv
// Top level of the serial mouse report encoder.
// Depends on smre_pkg, smre_front, smre_fifo and smre_back.
//
// Turns pointer events into five-byte serial mouse reports (sync byte with
// active-low buttons, then x1, y1, x2, y2). An X move, a Y move or a known
// button event produces one report; other axes and unknown buttons are
// accepted and produce nothing. Reports leave one byte per cycle, while
// out_stall_i is low, through a single output register; the front end keeps
// accepting items until the report queue (QueueDepth reports) is full, one
// item per cycle.
module serial_mouse_report_encoder_core #(
  parameter int QueueDepth = smre_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [1:0]         move_axis_i,
  input  logic signed [15:0] move_value_i,
  input  logic [1:0]         button_id_i,
  input  logic               pressed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         report_byte_o,
  output logic               last_of_report_o
);

  logic              q_push, q_full, q_pop, q_empty;
  smre_pkg::report_t q_wdata, q_rdata;

  smre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .move_axis_i  (move_axis_i),
    .move_value_i (move_value_i),
    .button_id_i  (button_id_i),
    .pressed_i    (pressed_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  smre_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  smre_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (~q_empty),
    .head_i           (q_rdata),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .report_byte_o    (report_byte_o),
    .last_of_report_o (last_of_report_o)
  );

endmodule
